### rtl/glyph_class_range_encoder_macros.svh
// Assertion macros shared by the glyph class range encoder.
`ifndef GLYPH_CLASS_RANGE_ENCODER_MACROS_SVH
`define GLYPH_CLASS_RANGE_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCRE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph class range encoder: check failed");

// Next-cycle implication, checked outside reset.
`define GCRE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph class range encoder: check failed");

`endif

### rtl/gcre_pkg.sv
// Shared types and constants of the glyph class range encoder.
package gcre_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam int FIELD_W = 16;
	localparam int NUM_W   = 17;
	localparam logic [NUM_W-1:0] COUNT_MAX = 17'h1FFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]         op;
		logic [FIELD_W-1:0] gid;
		logic [FIELD_W-1:0] cls;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] range_start;
		logic [FIELD_W-1:0] range_end;
		logic [FIELD_W-1:0] range_class;
		logic [NUM_W-1:0]   range_number;
	} result_t;

endpackage

### rtl/gcre_front.sv
// Front end: takes command words, drops the reserved code and queues the rest.
module gcre_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               action,
	input  logic [gcre_pkg::FIELD_W-1:0] glyph_id,
	input  logic [gcre_pkg::FIELD_W-1:0] glyph_class,
	input  logic                     clearing,
	input  logic                     pop,
	output logic                     busy,
	output logic                     q_valid,
	output gcre_pkg::cmd_t           q_cmd
);
	import gcre_pkg::*;

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              accept;
	logic              push;
	logic              do_pop;

	assign busy    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH)) || clearing;
	assign accept  = start && !busy;
	assign push    = accept && (action != OP_RSVD);
	assign q_valid = (count_q != '0);
	assign do_pop  = pop && q_valid;
	assign q_cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: action, gid: glyph_id, cls: glyph_class};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/gcre_back.sv
// Back end: class table memory, write and clear handling, and the range scanner.
module gcre_back #(
	parameter int GID_BITS   = 16,
	parameter int CLASS_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  gcre_pkg::cmd_t    q_cmd,
	output logic              pop,
	output logic              clearing,
	output logic              done,
	output gcre_pkg::result_t res
);
	import gcre_pkg::*;

	localparam int DEPTH = 1 << GID_BITS;
	localparam logic [GID_BITS:0] CURSOR_END = {1'b1, {GID_BITS{1'b0}}};

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SEEK, ST_RUN} state_t;

	logic [CLASS_BITS-1:0] mem [DEPTH];
	logic [CLASS_BITS-1:0] rd_data;
	logic                  we;
	logic [GID_BITS-1:0]   wa;
	logic [CLASS_BITS-1:0] wd;
	logic [GID_BITS-1:0]   ra;

	state_t                state_q;
	logic [GID_BITS-1:0]   clr_q;
	logic [GID_BITS:0]     cursor_q;
	logic [NUM_W-1:0]      count_q;
	logic [GID_BITS-1:0]   pa_q;
	logic [GID_BITS-1:0]   start_q;
	logic [CLASS_BITS-1:0] class_q;
	logic                  done_q;
	result_t               res_q;
	logic [NUM_W-1:0]      count_inc;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign clearing = (state_q == ST_CLEAR);
	assign done     = done_q;
	assign res      = res_q;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		ra = pa_q + 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				ra = cursor_q[GID_BITS-1:0];
				if (q_valid && q_cmd.op == OP_WRITE) begin
					we = 1'b1;
					wa = q_cmd.gid[GID_BITS-1:0];
					wd = q_cmd.cls[CLASS_BITS-1:0];
				end
			end
			ST_SEEK, ST_RUN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			cursor_q <= '0;
			count_q  <= '0;
			pa_q     <= '0;
			start_q  <= '0;
			class_q  <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op)
							OP_CLEAR: begin
								state_q  <= ST_CLEAR;
								clr_q    <= '0;
								cursor_q <= '0;
								count_q  <= '0;
							end
							OP_NEXT: begin
								if (cursor_q[GID_BITS]) begin
									done_q             <= 1'b1;
									res_q.found        <= 1'b0;
									res_q.range_start  <= '0;
									res_q.range_end    <= '0;
									res_q.range_class  <= '0;
									res_q.range_number <= count_q;
								end else begin
									pa_q    <= cursor_q[GID_BITS-1:0];
									state_q <= ST_SEEK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEEK: begin
					// rd_data belongs to glyph pa_q; the read of pa_q + 1 is already issued.
					if (rd_data == '0) begin
						if (&pa_q) begin
							cursor_q           <= CURSOR_END;
							done_q             <= 1'b1;
							res_q.found        <= 1'b0;
							res_q.range_start  <= '0;
							res_q.range_end    <= '0;
							res_q.range_class  <= '0;
							res_q.range_number <= count_q;
							state_q            <= ST_IDLE;
						end else begin
							pa_q <= pa_q + 1'b1;
						end
					end else if (&pa_q) begin
						cursor_q           <= CURSOR_END;
						count_q            <= count_inc;
						done_q             <= 1'b1;
						res_q.found        <= 1'b1;
						res_q.range_start  <= FIELD_W'(pa_q);
						res_q.range_end    <= FIELD_W'(pa_q);
						res_q.range_class  <= FIELD_W'(rd_data);
						res_q.range_number <= count_q;
						state_q            <= ST_IDLE;
					end else begin
						start_q <= pa_q;
						class_q <= rd_data;
						pa_q    <= pa_q + 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_data == class_q && !(&pa_q)) begin
						pa_q <= pa_q + 1'b1;
					end else begin
						// The run ends either at the last glyph or just before pa_q.
						count_q            <= count_inc;
						done_q             <= 1'b1;
						res_q.found        <= 1'b1;
						res_q.range_start  <= FIELD_W'(start_q);
						res_q.range_class  <= FIELD_W'(class_q);
						res_q.range_number <= count_q;
						state_q            <= ST_IDLE;
						if (rd_data == class_q) begin
							cursor_q        <= CURSOR_END;
							res_q.range_end <= FIELD_W'(pa_q);
						end else begin
							cursor_q        <= (GID_BITS+1)'(pa_q);
							res_q.range_end <= FIELD_W'(pa_q - 1'b1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/glyph_class_range_encoder.sv
// Top level of the glyph class range encoder: command queue and range scanner.
//
//   channel   ports                                        handshake
//   command   action, glyph_id, glyph_class                start high, busy low
//   result    found, range_start, range_end, range_class,  done high for one cycle
//             range_number
//
// A write word is taken by the scanner in its idle state; a next-range word reads the
// class table one entry a cycle, through each glyph examined, the glyph that ends a
// run included.
// A request with the table already exhausted answers from the idle state, with no scan.
// After reset and after each clear word the table is swept to zero, one entry a cycle;
// busy stays high during the sweep.
// A four-word queue lets the loader keep writing while the scanner works; busy rises only
// when the queue is full or a sweep runs. Results cannot be held off by the receiver.
`include "glyph_class_range_encoder_macros.svh"

module glyph_class_range_encoder #(
	parameter int GID_BITS   = 16,
	parameter int CLASS_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [gcre_pkg::FIELD_W-1:0] glyph_id,
	input  logic [gcre_pkg::FIELD_W-1:0] glyph_class,
	output logic                         done,
	output logic                         found,
	output logic [gcre_pkg::FIELD_W-1:0] range_start,
	output logic [gcre_pkg::FIELD_W-1:0] range_end,
	output logic [gcre_pkg::FIELD_W-1:0] range_class,
	output logic [gcre_pkg::NUM_W-1:0]   range_number
);
	import gcre_pkg::*;

	logic    q_valid;
	cmd_t    q_cmd;
	logic    pop;
	logic    clearing;
	result_t res;

	gcre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.glyph_id    (glyph_id),
		.glyph_class (glyph_class),
		.clearing    (clearing),
		.pop         (pop),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd)
	);

	gcre_back #(
		.GID_BITS   (GID_BITS),
		.CLASS_BITS (CLASS_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.res      (res)
	);

	assign found        = res.found;
	assign range_start  = res.range_start;
	assign range_end    = res.range_end;
	assign range_class  = res.range_class;
	assign range_number = res.range_number;

	`GCRE_ASSERT_NOW(a_empty_result_zero, done && !found,
		range_start == '0 && range_end == '0 && range_class == '0)
	`GCRE_ASSERT_NOW(a_range_ordered, done && found, range_start <= range_end && range_class != '0)
	`GCRE_ASSERT_NOW(a_busy_while_clearing, clearing, busy && !pop)

endmodule
